/* rtl/trsc_pkg.sv */
package trsc_pkg;

	// item kinds carried in s_tuser
	localparam logic [1:0] MODE_LOAD    = 2'd0;
	localparam logic [1:0] MODE_ENC     = 2'd1;
	localparam logic [1:0] MODE_DEC     = 2'd2;
	localparam logic [1:0] MODE_RESTART = 2'd3;

	// lookup stages of one letter
	localparam logic [1:0] STG_SEARCH_A = 2'd0;
	localparam logic [1:0] STG_READ_MID = 2'd1;
	localparam logic [1:0] STG_SEARCH_B = 2'd2;
	localparam logic [1:0] STG_READ_END = 2'd3;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_ACCEPT,
		OP_SEARCH,
		OP_READ,
		OP_CAP_Q,
		OP_CAP_RES,
		OP_OUT_LOAD
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] stage;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       letter;
		logic       done;
	} sts_t;

endpackage

/* rtl/trsc_ram.sv */
module trsc_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 78
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* rtl/trsc_datapath.sv */
module trsc_datapath #(
	parameter int ALPHABET_SIZE = 26
) (
	input  logic            clk,
	input  logic            arst_n,
	input  trsc_pkg::cmd_t  cmd,
	output trsc_pkg::sts_t  sts,
	input  logic [1:0]      mode,
	input  logic [1:0]      rotor_sel,
	input  logic [4:0]      entry_index,
	input  logic [4:0]      wire_in_side,
	input  logic [4:0]      wire_out_side,
	input  logic [7:0]      char_in,
	output logic [7:0]      char_out,
	output logic            no_match
);

	import trsc_pkg::*;

	localparam int N  = ALPHABET_SIZE;
	localparam int OW = (N > 1) ? $clog2(N) : 1;
	localparam int JW = $clog2(N + 1);
	localparam int AW = $clog2(3 * N);
	localparam logic [AW-1:0] BASE0 = '0;
	localparam logic [AW-1:0] BASE1 = AW'(N);
	localparam logic [AW-1:0] BASE2 = AW'(2 * N);
	localparam logic [OW-1:0] LAST  = OW'(N - 1);

	logic          enc_q;
	logic [4:0]    val_q;
	logic [JW-1:0] j_q;
	logic [OW-1:0] jd_s1;
	logic          vld_s1;
	logic [OW-1:0] jres_q;
	logic          miss_q;
	logic [7:0]    res_char_q;
	logic          res_nm_q;
	logic [7:0]    out_char_q;
	logic          out_nm_q;
	logic [OW-1:0] off_q [3];
	logic [OW-1:0] lo_q;
	logic [OW-1:0] hi_q;
	logic          due1_q;
	logic          due2_q;

	logic [7:0]    ch_up;
	logic          letter;
	logic [1:0]    rot;
	logic          field_first;
	logic [AW-1:0] base;
	logic [OW-1:0] offs;
	logic [OW-1:0] jx;
	logic [OW:0]   sum;
	logic [OW:0]   ptr;
	logic [AW-1:0] rd_addr;
	logic [9:0]    rd_data;
	logic [4:0]    rd_field;
	logic          hit;
	logic          we;
	logic [AW-1:0] wbase;
	logic [AW-1:0] wr_addr;
	logic          lo_wrap;
	logic          j_open;

	function automatic logic [OW-1:0] step_wrap(input logic [OW-1:0] o);
		step_wrap = (o == LAST) ? '0 : o + OW'(1);
	endfunction

	// fold lower case, then classify
	assign ch_up  = (char_in >= 8'h61 && char_in <= 8'h7a) ? char_in - 8'd32 : char_in;
	assign letter = (ch_up >= 8'h41 && ch_up <= 8'h5a);

	// rotor and wiring side used by each stage
	always_comb begin
		case (cmd.stage)
			STG_SEARCH_A: rot = enc_q ? 2'd0 : 2'd2;
			STG_READ_END: rot = enc_q ? 2'd2 : 2'd0;
			default:      rot = 2'd1;
		endcase
	end
	assign field_first = cmd.stage[0] ? enc_q : !enc_q;

	always_comb begin
		case (rot)
			2'd0:    begin base = BASE0; offs = off_q[0]; end
			2'd1:    begin base = BASE1; offs = off_q[1]; end
			default: begin base = BASE2; offs = off_q[2]; end
		endcase
	end

	assign jx      = (cmd.op == OP_READ) ? jres_q : j_q[OW-1:0];
	assign sum     = {1'b0, jx} + {1'b0, offs};
	assign ptr     = (sum >= (OW+1)'(N)) ? sum - (OW+1)'(N) : sum;
	assign rd_addr = AW'(32'(base) + 32'(ptr));

	assign rd_field = field_first ? rd_data[4:0] : rd_data[9:5];
	assign hit      = (rd_field == val_q);
	assign j_open   = (j_q < JW'(N));

	always_comb begin
		case (rotor_sel)
			2'd0:    wbase = BASE0;
			2'd1:    wbase = BASE1;
			default: wbase = BASE2;
		endcase
	end
	assign we = (cmd.op == OP_ACCEPT) && (mode == MODE_LOAD) && (rotor_sel != 2'd3)
		&& ({1'b0, entry_index} < 6'(N));
	assign wr_addr = AW'(32'(wbase) + 32'(entry_index));

	trsc_ram #(
		.WIDTH(10),
		.DEPTH(3 * N)
	) u_ram (
		.clk    (clk),
		.we     (we),
		.wr_addr(wr_addr),
		.wr_data({wire_out_side, wire_in_side}),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign sts.mode   = mode;
	assign sts.letter = letter;
	assign sts.done   = vld_s1 && (hit || jd_s1 == LAST);

	assign lo_wrap = (lo_q == LAST);

	// rotor positions, letter count and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q[0] <= '0;
			off_q[1] <= '0;
			off_q[2] <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			due1_q   <= 1'b0;
			due2_q   <= 1'b0;
			j_q      <= '0;
			vld_s1   <= 1'b0;
		end else begin
			case (cmd.op)
				OP_ACCEPT: begin
					j_q    <= '0;
					vld_s1 <= 1'b0;
					if (mode == MODE_RESTART) begin
						off_q[0] <= '0;
						off_q[1] <= '0;
						off_q[2] <= '0;
						lo_q     <= '0;
						hi_q     <= '0;
					end else if ((mode == MODE_ENC || mode == MODE_DEC) && letter) begin
						lo_q   <= step_wrap(lo_q);
						due1_q <= lo_wrap;
						due2_q <= lo_wrap && (hi_q == LAST);
						if (lo_wrap) begin
							hi_q <= step_wrap(hi_q);
						end
					end
				end
				OP_SEARCH: begin
					if (j_open) begin
						j_q <= j_q + JW'(1);
					end
					vld_s1 <= j_open;
				end
				OP_CAP_Q: begin
					j_q    <= '0;
					vld_s1 <= 1'b0;
				end
				OP_CAP_RES: begin
					off_q[0] <= step_wrap(off_q[0]);
					if (due1_q) begin
						off_q[1] <= step_wrap(off_q[1]);
					end
					if (due2_q) begin
						off_q[2] <= step_wrap(off_q[2]);
					end
				end
				default: ;
			endcase
		end
	end

	// item payload and results
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ACCEPT: begin
				enc_q      <= (mode == MODE_ENC);
				val_q      <= ch_up[4:0];
				miss_q     <= 1'b0;
				res_char_q <= 8'd32;
				res_nm_q   <= 1'b0;
			end
			OP_SEARCH: begin
				jd_s1 <= j_q[OW-1:0];
				if (sts.done) begin
					jres_q <= hit ? jd_s1 : '0;
					if (!hit) begin
						miss_q <= 1'b1;
					end
				end
			end
			OP_CAP_Q: begin
				val_q <= rd_field;
			end
			OP_CAP_RES: begin
				res_char_q <= (rd_field >= 5'd1 && rd_field <= 5'd26)
					? 8'h60 + {3'b000, rd_field} : 8'h40 + {3'b000, rd_field};
				res_nm_q   <= miss_q;
			end
			OP_OUT_LOAD: begin
				out_char_q <= res_char_q;
				out_nm_q   <= res_nm_q;
			end
			default: ;
		endcase
	end

	assign char_out = out_char_q;
	assign no_match = out_nm_q;

endmodule

/* rtl/trsc_ctrl.sv */
module trsc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  trsc_pkg::sts_t sts,
	output trsc_pkg::cmd_t cmd
);

	import trsc_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SRCH1 = 3'd1;
	localparam logic [2:0] ST_RD2   = 3'd2;
	localparam logic [2:0] ST_CAP2  = 3'd3;
	localparam logic [2:0] ST_SRCH2 = 3'd4;
	localparam logic [2:0] ST_RD3   = 3'd5;
	localparam logic [2:0] ST_CAP3  = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       ov_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = ov_q;

	always_comb begin
		state_d   = state_q;
		cmd.op    = OP_NONE;
		cmd.stage = STG_SEARCH_A;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.op = OP_ACCEPT;
					if (sts.mode == MODE_ENC || sts.mode == MODE_DEC) begin
						state_d = sts.letter ? ST_SRCH1 : ST_DONE;
					end
				end
			end
			ST_SRCH1: begin
				cmd.op    = OP_SEARCH;
				cmd.stage = STG_SEARCH_A;
				if (sts.done) begin
					state_d = ST_RD2;
				end
			end
			ST_RD2: begin
				cmd.op    = OP_READ;
				cmd.stage = STG_READ_MID;
				state_d   = ST_CAP2;
			end
			ST_CAP2: begin
				cmd.op    = OP_CAP_Q;
				cmd.stage = STG_READ_MID;
				state_d   = ST_SRCH2;
			end
			ST_SRCH2: begin
				cmd.op    = OP_SEARCH;
				cmd.stage = STG_SEARCH_B;
				if (sts.done) begin
					state_d = ST_RD3;
				end
			end
			ST_RD3: begin
				cmd.op    = OP_READ;
				cmd.stage = STG_READ_END;
				state_d   = ST_CAP3;
			end
			ST_CAP3: begin
				cmd.op    = OP_CAP_RES;
				cmd.stage = STG_READ_END;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (!ov_q || m_tready) begin
					cmd.op  = OP_OUT_LOAD;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == OP_OUT_LOAD) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/three_rotor_stepping_cipher.sv */
// three-rotor stepping substitution cipher with a registered stream output. a load item
// (s_tuser 0) writes one wiring pair of one rotor; a restart item (s_tuser 3) zeroes the
// rotor positions and the letter count; encrypt (1) and decrypt (2) items return one
// character each (lower case for a wiring value of 1 to 26), or a space for a non-letter.
// both wiring lookups of a letter scan the rotor one entry per cycle through the single
// read port of the wiring memory, and stop early on a hit. a non-letter skips the
// lookups. wiring entries must be loaded before they are used; they have no reset.
// no_match flags a lookup that found no entry
module three_rotor_stepping_cipher #(
	parameter int ALPHABET_SIZE = 26
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// rotor_sel [1:0], entry_index [6:2], wire_in_side [11:7], wire_out_side [16:12],
	// char_in [24:17], zero fill above
	input  logic [31:0] s_tdata,
	// mode [1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// char_out [7:0]
	output logic [7:0]  m_tdata,
	// no_match [0]
	output logic [0:0]  m_tuser
);

	import trsc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer: one state per lookup step, output transfer held in its own register
	trsc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// wiring memory, rotor positions, letter count and result registers
	trsc_datapath #(
		.ALPHABET_SIZE(ALPHABET_SIZE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.mode         (s_tuser),
		.rotor_sel    (s_tdata[1:0]),
		.entry_index  (s_tdata[6:2]),
		.wire_in_side (s_tdata[11:7]),
		.wire_out_side(s_tdata[16:12]),
		.char_in      (s_tdata[24:17]),
		.char_out     (m_tdata),
		.no_match     (m_tuser[0])
	);

endmodule

/* rtl/trsc_checker.sv */
module trsc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [1:0] s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [0:0] m_tuser
);

	import trsc_pkg::*;

	// a waiting result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a waiting result keeps its value
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// load and restart transfers never raise a result
	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == MODE_LOAD || s_tuser == MODE_RESTART)
		|=> !$rose(m_tvalid))
		else $error("result after load or restart");

	// a character item keeps the input closed while it is worked on
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == MODE_ENC || s_tuser == MODE_DEC) |=> !s_tready)
		else $error("input reopened during a character");

	// a result is a space or a character in the letter band
	a_char_band: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata == 8'd32 || m_tdata[7:6] == 2'b01)
		else $error("result outside letter band");

endmodule

bind three_rotor_stepping_cipher trsc_checker u_chk (.*);

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;
	import trsc_pkg::*;

	localparam int ALPHA       = 26;
	localparam int CYCLE_LIMIT = 600000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic [0:0]  m_tuser;

	three_rotor_stepping_cipher #(.ALPHABET_SIZE(ALPHA)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// one expected letter result
	typedef struct {
		logic [7:0] ch;
		logic       nm;
	} letter_t;

	// directed row: chk means the result is typed in rather than predicted
	typedef struct {
		logic [1:0] mode;
		logic [1:0] sel;
		logic [4:0] idx;
		logic [4:0] win;
		logic [4:0] wout;
		logic [7:0] ch;
		bit         chk;
		logic [7:0] exp_ch;
		logic       exp_nm;
	} row_t;

	// shadow of the cipher state
	logic [4:0] wire_a [3*ALPHA];
	logic [4:0] wire_b [3*ALPHA];
	int         pos [3];
	int         letters_seen;

	letter_t    pending_letters [$];
	int         errors;
	int         cycles;
	int         snd_idle;
	int         rcv_idle;
	int         hold_left;

	// clock, 2 ns period
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int slot(int r, int j);
		return r * ALPHA + (j + pos[r]) % ALPHA;
	endfunction

	// scan a rotor for a value on either side, entry 0 on a miss
	function automatic int scan_rotor(int r, bit by_a, int val, ref bit miss);
		int j;
		for (j = 0; j < ALPHA; j++) begin
			if ((by_a ? wire_a[slot(r, j)] : wire_b[slot(r, j)]) == val)
				return j;
		end
		miss = 1'b1;
		return 0;
	endfunction

	function automatic void step_rotor(int r);
		pos[r] = (pos[r] + 1) % ALPHA;
	endfunction

	// updates the shadow state; returns 1 when the item gives a result
	function automatic bit cipher_predict(logic [1:0] mode, logic [1:0] sel, logic [4:0] idx,
			logic [4:0] win, logic [4:0] wout, logic [7:0] ch, output letter_t res);
		int  c, p, j, v, o;
		bit  miss;
		miss = 1'b0;
		res.ch = 8'd32;
		res.nm = 1'b0;
		if (mode == MODE_LOAD) begin
			if (sel < 3 && idx < ALPHA) begin
				wire_a[sel * ALPHA + idx] = win;
				wire_b[sel * ALPHA + idx] = wout;
			end
			return 1'b0;
		end
		if (mode == MODE_RESTART) begin
			pos[0] = 0;
			pos[1] = 0;
			pos[2] = 0;
			letters_seen = 0;
			return 1'b0;
		end
		c = ch;
		if (c >= 97 && c <= 122)
			c -= 32;
		if (c < 65 || c > 90)
			return 1'b1;
		p = c - 64;
		letters_seen = (letters_seen + 1) % (ALPHA * ALPHA);
		if (mode == MODE_ENC) begin
			j = scan_rotor(0, 1'b0, p, miss);
			step_rotor(0);
			p = wire_a[slot(1, j)];
			j = scan_rotor(1, 1'b0, p, miss);
			if (letters_seen % ALPHA == 0)
				step_rotor(1);
			v = wire_a[slot(2, j)];
			if (letters_seen == 0)
				step_rotor(2);
		end else begin
			j = scan_rotor(2, 1'b1, p, miss);
			if (letters_seen == 0)
				step_rotor(2);
			p = wire_b[slot(1, j)];
			j = scan_rotor(1, 1'b1, p, miss);
			if (letters_seen % ALPHA == 0)
				step_rotor(1);
			v = wire_b[slot(0, j)];
			step_rotor(0);
		end
		o = (v + 64) & 255;
		if (o >= 65 && o <= 90)
			o += 32;
		res.ch = o[7:0];
		res.nm = miss;
		return 1'b1;
	endfunction

	// offer one item, wait for its transfer, then predict; row_chk overrides the prediction
	task automatic send_item(logic [1:0] mode, logic [1:0] sel, logic [4:0] idx, logic [4:0] win,
			logic [4:0] wout, logic [7:0] ch, bit row_chk, logic [7:0] row_ch, logic row_nm);
		letter_t r;
		while ($urandom_range(99) < snd_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {7'd0, ch, wout, win, idx, sel};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (cipher_predict(mode, sel, idx, win, wout, ch, r)) begin
			if (row_chk) begin
				r.ch = row_ch;
				r.nm = row_nm;
			end
			pending_letters = {pending_letters, r};
		end
	endtask

	// receiver: random stalls, plus a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rcv_idle);
		end
	end

	// result checker
	always @(posedge clk) begin
		letter_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_letters.size() == 0) begin
				$error("unexpected result char_out %0d no_match %0d", m_tdata, m_tuser);
				errors++;
			end else begin
				e = pending_letters.pop_front();
				if (m_tdata !== e.ch) begin
					$error("char_out expected %0d actual %0d", e.ch, m_tdata);
					errors++;
				end
				if (m_tuser[0] !== e.nm) begin
					$error("no_match expected %0d actual %0d", e.nm, m_tuser[0]);
					errors++;
				end
			end
		end
	end

	row_t dir_rows [] = '{
		// non-letters at the edges of the byte and letter ranges give a space and step nothing
		'{MODE_ENC, 2'd0, 5'd0, 5'd0, 5'd0, 8'd0, 1, 8'd32, 1'b0},
		'{MODE_ENC, 2'd3, 5'd31, 5'd31, 5'd31, 8'd255, 1, 8'd32, 1'b0},
		'{MODE_DEC, 2'd0, 5'd0, 5'd0, 5'd0, 8'd64, 1, 8'd32, 1'b0},
		'{MODE_DEC, 2'd0, 5'd0, 5'd0, 5'd0, 8'd91, 1, 8'd32, 1'b0},
		'{MODE_ENC, 2'd0, 5'd0, 5'd0, 5'd0, 8'd96, 1, 8'd32, 1'b0},
		'{MODE_ENC, 2'd0, 5'd0, 5'd0, 5'd0, 8'd123, 1, 8'd32, 1'b0},
		// letters at both ends in both cases
		'{MODE_ENC, 2'd0, 5'd0, 5'd0, 5'd0, 8'd65, 0, 8'd0, 1'b0},
		'{MODE_ENC, 2'd0, 5'd0, 5'd0, 5'd0, 8'd90, 0, 8'd0, 1'b0},
		'{MODE_ENC, 2'd0, 5'd0, 5'd0, 5'd0, 8'd97, 0, 8'd0, 1'b0},
		'{MODE_ENC, 2'd0, 5'd0, 5'd0, 5'd0, 8'd122, 0, 8'd0, 1'b0},
		'{MODE_RESTART, 2'd0, 5'd0, 5'd0, 5'd0, 8'd0, 0, 8'd0, 1'b0},
		'{MODE_DEC, 2'd0, 5'd0, 5'd0, 5'd0, 8'd65, 0, 8'd0, 1'b0},
		'{MODE_DEC, 2'd0, 5'd0, 5'd0, 5'd0, 8'd122, 0, 8'd0, 1'b0},
		// loads that must be ignored
		'{MODE_LOAD, 2'd3, 5'd0, 5'd31, 5'd31, 8'd0, 0, 8'd0, 1'b0},
		'{MODE_LOAD, 2'd0, 5'd26, 5'd0, 5'd0, 8'd0, 0, 8'd0, 1'b0},
		'{MODE_LOAD, 2'd1, 5'd31, 5'd0, 5'd0, 8'd0, 0, 8'd0, 1'b0},
		'{MODE_RESTART, 2'd0, 5'd0, 5'd0, 5'd0, 8'd0, 0, 8'd0, 1'b0},
		'{MODE_ENC, 2'd0, 5'd0, 5'd0, 5'd0, 8'd77, 0, 8'd0, 1'b0},
		// out-of-range wiring values: failed lookups and odd result codes
		'{MODE_LOAD, 2'd2, 5'd25, 5'd31, 5'd0, 8'd0, 0, 8'd0, 1'b0},
		'{MODE_LOAD, 2'd0, 5'd0, 5'd0, 5'd31, 8'd0, 0, 8'd0, 1'b0},
		'{MODE_ENC, 2'd0, 5'd0, 5'd0, 5'd0, 8'd84, 0, 8'd0, 1'b0},
		'{MODE_DEC, 2'd0, 5'd0, 5'd0, 5'd0, 8'd120, 0, 8'd0, 1'b0},
		'{MODE_DEC, 2'd0, 5'd0, 5'd0, 5'd0, 8'd66, 0, 8'd0, 1'b0},
		'{MODE_ENC, 2'd0, 5'd0, 5'd0, 5'd0, 8'd67, 0, 8'd0, 1'b0}
	};

	initial begin
		int ph, k, r, i, t;
		logic [7:0] c;
		errors       = 0;
		cycles       = 0;
		hold_left    = 0;
		snd_idle     = 0;
		rcv_idle     = 0;
		pos[0]       = 0;
		pos[1]       = 0;
		pos[2]       = 0;
		letters_seen = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = MODE_LOAD;
		m_tready = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill all wiring with permutations so that nothing unwritten is ever read
		for (r = 0; r < 3; r++)
			for (i = 0; i < ALPHA; i++)
				send_item(MODE_LOAD, r[1:0], i[4:0], 5'((i * 7 + r * 3) % ALPHA + 1),
					5'((i * 11 + r * 5) % ALPHA + 1), 8'd0, 0, 8'd0, 1'b0);

		foreach (dir_rows[k])
			send_item(dir_rows[k].mode, dir_rows[k].sel, dir_rows[k].idx, dir_rows[k].win,
				dir_rows[k].wout, dir_rows[k].ch, dir_rows[k].chk, dir_rows[k].exp_ch,
				dir_rows[k].exp_nm);

		// long receiver hold-off while the sender keeps offering
		hold_left = 400;

		// idling phases: none, sender, receiver, both; restarts only in the first so
		// later phases run long enough for rotor three to step
		for (ph = 0; ph < 4; ph++) begin
			snd_idle = (ph == 1) ? 87 : (ph == 3) ? 32 : 0;
			rcv_idle = (ph == 2) ? 87 : (ph == 3) ? 32 : 0;
			for (k = 0; k < 362; k++) begin
				t = $urandom_range(99);
				if (t < 7) begin
					// rewire one entry, mostly with proper letter numbers
					send_item(MODE_LOAD, 2'($urandom_range(2)), 5'($urandom_range(ALPHA - 1)),
						($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(26, 1)),
						($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(26, 1)),
						8'($urandom), 0, 8'd0, 1'b0);
				end else if (t < 9) begin
					send_item(MODE_LOAD, ($urandom_range(1)) ? 2'd3 : 2'($urandom),
						5'($urandom_range(31, ALPHA)), 5'($urandom), 5'($urandom),
						8'($urandom), 0, 8'd0, 1'b0);
				end else if (t < 10 && ph == 0) begin
					send_item(MODE_RESTART, 2'($urandom), 5'($urandom), 5'($urandom),
						5'($urandom), 8'($urandom), 0, 8'd0, 1'b0);
				end else begin
					if (t < 22) begin
						// any byte that is not a letter
						c = 8'($urandom);
						while ((c >= 65 && c <= 90) || (c >= 97 && c <= 122))
							c = 8'($urandom);
					end else begin
						c = 8'($urandom_range(90, 65));
						if ($urandom_range(1))
							c = c + 8'd32;
					end
					send_item(($urandom_range(1)) ? MODE_ENC : MODE_DEC, 2'($urandom),
						5'($urandom), 5'($urandom), 5'($urandom), c, 0, 8'd0, 1'b0);
				end
			end
		end
		s_tvalid <= 1'b0;

		while (pending_letters.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/trsc_pkg.sv
rtl/trsc_ram.sv
rtl/trsc_datapath.sv
rtl/trsc_ctrl.sv
rtl/three_rotor_stepping_cipher.sv
rtl/trsc_checker.sv
tb/tb.sv
